// ===== hdl/frame_replacement_order_list_macros.svh =====
// Assertion macros used by the checked module.
`ifndef FRAME_REPLACEMENT_ORDER_LIST_MACROS_SVH
`define FRAME_REPLACEMENT_ORDER_LIST_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define FRL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define FRL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/frl_pkg.sv =====
package frl_pkg;

    localparam int MAX_FRAMES = 64;
    localparam int ADDR_W     = $clog2(MAX_FRAMES);
    localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
    localparam int CFG_W      = 7;
    localparam int PID_W      = 16;
    localparam int PAGE_W     = 10;
    localparam int FRAME_W    = 6;
    localparam int ENTRY_W    = PID_W + PAGE_W + FRAME_W;

    typedef enum logic [1:0] {
        REQ_LOAD    = 2'd0,
        REQ_REPLACE = 2'd1,
        REQ_TOUCH   = 2'd2,
        REQ_REMOVE  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_LOAD_FULL  = 2'd1,
        ST_REPL_EMPTY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_SH_RD,
        S_SH_WR,
        S_TAIL,
        S_DONE
    } t_state;

endpackage

// ===== hdl/frl_ram.sv =====
module frl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/frame_replacement_order_list.sv =====
// Ordered list of up to 64 resident frames, oldest at the head, held in a single-port-write,
// registered-read RAM. A request is taken when start is high and busy is low; its result
// appears on the o_ ports for exactly one cycle with o_result_valid high and cannot be held
// off. A replace, touch or remove walks the list through one compare unit, one RAM read at
// a time. A load that is stored goes straight to the tail write and then the result; a load
// on a full list and a replace, touch or remove on an empty list go straight to the result.
// A replace, touch or remove that matches scans up to the match, then reads and writes each
// entry behind it one place toward the head, then takes the tail step (a write for replace
// and touch, a count update for remove) and the result. A touch or remove that finds
// nothing scans the whole list and then gives the result.
// The frame count register has its own channel, which is always ready; write it only while
// no request is in flight. Values of 0 act as 1 and values above 64 act as 64.
module frame_replacement_order_list
    import frl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_req_type,
    input  logic [PID_W-1:0]   i_proc_id,
    input  logic [PAGE_W-1:0]  i_page_num,
    input  logic [FRAME_W-1:0] i_frame_num,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CFG_W-1:0]   i_cfg_data,
    output logic               o_result_valid,
    output logic [FRAME_W-1:0] o_victim_frame,
    output logic [PID_W-1:0]   o_victim_pid,
    output logic [PAGE_W-1:0]  o_victim_page,
    output logic               o_found,
    output logic               o_list_full,
    output logic [CNT_W-1:0]   o_entry_count,
    output logic [1:0]         o_status
);

    `include "frame_replacement_order_list_macros.svh"

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CFG_W-1:0]    r_frame_count;
    t_req                r_req, n_req;
    logic [PID_W-1:0]    r_pid, n_pid;
    logic [PAGE_W-1:0]   r_page, n_page;
    logic [FRAME_W-1:0]  r_frame, n_frame;
    logic [ENTRY_W-1:0]  r_hit, n_hit;
    logic [FRAME_W-1:0]  r_victim_frame, n_victim_frame;
    logic [PID_W-1:0]    r_victim_pid, n_victim_pid;
    logic [PAGE_W-1:0]   r_victim_page, n_victim_page;
    logic                r_found, n_found;
    t_status             r_status, n_status;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;

    logic [CNT_W-1:0]    w_cap;
    logic [CNT_W-1:0]    w_idx_inc;
    logic [CNT_W-1:0]    w_idx_inc2;
    logic [CNT_W-1:0]    w_last;
    logic [ENTRY_W-1:0]  w_key;
    logic [ENTRY_W-1:0]  w_mask;
    logic                w_match;

    frl_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(MAX_FRAMES)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        if (r_frame_count == '0) begin
            w_cap = CNT_W'(1);
        end else if (r_frame_count > CFG_W'(MAX_FRAMES)) begin
            w_cap = CNT_W'(MAX_FRAMES);
        end else begin
            w_cap = CNT_W'(r_frame_count);
        end
    end

    assign w_idx_inc  = r_idx + CNT_W'(1);
    assign w_idx_inc2 = r_idx + CNT_W'(2);
    assign w_last     = r_count - CNT_W'(1);

    // The one comparator: a replace masks everything off so the head always matches,
    // a touch compares pid and page, a remove compares the frame.
    always_comb begin
        unique case (r_req)
            REQ_TOUCH: begin
                w_key  = {r_pid, r_page, {FRAME_W{1'b0}}};
                w_mask = {{(PID_W + PAGE_W){1'b1}}, {FRAME_W{1'b0}}};
            end
            REQ_REMOVE: begin
                w_key  = {{(PID_W + PAGE_W){1'b0}}, r_frame};
                w_mask = {{(PID_W + PAGE_W){1'b0}}, {FRAME_W{1'b1}}};
            end
            REQ_LOAD, REQ_REPLACE: begin
                w_key  = '0;
                w_mask = '0;
            end
        endcase
    end

    assign w_match = (((ram_rdata ^ w_key) & w_mask) == '0);

    always_comb begin
        n_state        = r_state;
        n_idx          = r_idx;
        n_count        = r_count;
        n_req          = r_req;
        n_pid          = r_pid;
        n_page         = r_page;
        n_frame        = r_frame;
        n_hit          = r_hit;
        n_victim_frame = r_victim_frame;
        n_victim_pid   = r_victim_pid;
        n_victim_page  = r_victim_page;
        n_found        = r_found;
        n_status       = r_status;
        ram_we         = 1'b0;
        ram_waddr      = r_idx[ADDR_W-1:0];
        ram_wdata      = r_hit;
        ram_raddr      = r_idx[ADDR_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req          = t_req'(i_req_type);
                    n_pid          = i_proc_id;
                    n_page         = i_page_num;
                    n_frame        = i_frame_num;
                    n_idx          = '0;
                    n_found        = 1'b0;
                    n_status       = ST_OK;
                    n_victim_frame = '0;
                    n_victim_pid   = '0;
                    n_victim_page  = '0;
                    unique case (t_req'(i_req_type))
                        REQ_LOAD: begin
                            if (r_count >= w_cap) begin
                                n_status = ST_LOAD_FULL;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_TAIL;
                            end
                        end
                        REQ_REPLACE: begin
                            if (r_count == '0) begin
                                n_status = ST_REPL_EMPTY;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_RD;
                            end
                        end
                        REQ_TOUCH, REQ_REMOVE: begin
                            n_state = (r_count == '0) ? S_DONE : S_RD;
                        end
                    endcase
                end
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (w_match) begin
                    n_hit = ram_rdata;
                    if (r_req == REQ_REPLACE) begin
                        n_victim_pid   = ram_rdata[ENTRY_W-1 -: PID_W];
                        n_victim_page  = ram_rdata[FRAME_W +: PAGE_W];
                        n_victim_frame = ram_rdata[FRAME_W-1:0];
                    end else begin
                        n_found = 1'b1;
                    end
                    n_state = (w_idx_inc < r_count) ? S_SH_RD : S_TAIL;
                end else begin
                    n_idx   = w_idx_inc;
                    n_state = (w_idx_inc < r_count) ? S_RD : S_DONE;
                end
            end
            S_SH_RD: begin
                ram_raddr = w_idx_inc[ADDR_W-1:0];
                n_state   = S_SH_WR;
            end
            S_SH_WR: begin
                // The entry behind the gap moves one place toward the head.
                ram_we    = 1'b1;
                ram_waddr = r_idx[ADDR_W-1:0];
                ram_wdata = ram_rdata;
                n_idx     = w_idx_inc;
                n_state   = (w_idx_inc2 < r_count) ? S_SH_RD : S_TAIL;
            end
            S_TAIL: begin
                unique case (r_req)
                    REQ_LOAD: begin
                        ram_we    = 1'b1;
                        ram_waddr = r_count[ADDR_W-1:0];
                        ram_wdata = {r_pid, r_page, r_frame};
                        n_count   = r_count + CNT_W'(1);
                    end
                    REQ_REPLACE: begin
                        ram_we    = 1'b1;
                        ram_waddr = w_last[ADDR_W-1:0];
                        ram_wdata = {r_pid, r_page, r_hit[FRAME_W-1:0]};
                    end
                    REQ_TOUCH: begin
                        ram_we    = 1'b1;
                        ram_waddr = w_last[ADDR_W-1:0];
                        ram_wdata = r_hit;
                    end
                    REQ_REMOVE: begin
                        n_count = w_last;
                    end
                endcase
                n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_count       <= '0;
            r_frame_count <= CFG_W'(MAX_FRAMES);
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_valid && o_cfg_ready) begin
                r_frame_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx          <= n_idx;
        r_req          <= n_req;
        r_pid          <= n_pid;
        r_page         <= n_page;
        r_frame        <= n_frame;
        r_hit          <= n_hit;
        r_victim_frame <= n_victim_frame;
        r_victim_pid   <= n_victim_pid;
        r_victim_page  <= n_victim_page;
        r_found        <= n_found;
        r_status       <= n_status;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_result_valid = (r_state == S_DONE);
    assign o_victim_frame = r_victim_frame;
    assign o_victim_pid   = r_victim_pid;
    assign o_victim_page  = r_victim_page;
    assign o_found        = r_found;
    assign o_list_full    = (r_count >= w_cap);
    assign o_entry_count  = r_count;
    assign o_status       = r_status;

    `FRL_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNT_W'(MAX_FRAMES), "entry count overflow")
    `FRL_ASSERT_NEXT(a_single_strobe, o_result_valid, !o_result_valid && !busy, "strobe too long")
    `FRL_ASSERT_NOW(a_full_on_reject, o_result_valid && (o_status == ST_LOAD_FULL), o_list_full, "bad reject")
    `FRL_ASSERT_NOW(a_shift_in_range, r_state == S_SH_WR, w_idx_inc < r_count, "shift beyond list end")

endmodule

// ===== tb/frl_order_checker.sv =====
`timescale 1ns / 1ps

module frl_order_checker
    import frl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [1:0]         i_req_type,
    input  logic [PID_W-1:0]   i_proc_id,
    input  logic [PAGE_W-1:0]  i_page_num,
    input  logic [FRAME_W-1:0] i_frame_num,
    input  logic               i_cfg_valid,
    input  logic               o_cfg_ready,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic               o_result_valid,
    input  logic [FRAME_W-1:0] o_victim_frame,
    input  logic [PID_W-1:0]   o_victim_pid,
    input  logic [PAGE_W-1:0]  o_victim_page,
    input  logic               o_found,
    input  logic               o_list_full,
    input  logic [CNT_W-1:0]   o_entry_count,
    input  logic [1:0]         o_status,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct packed {
        logic [FRAME_W-1:0] victim_frame;
        logic [PID_W-1:0]   victim_pid;
        logic [PAGE_W-1:0]  victim_page;
        logic               found;
        logic               list_full;
        logic [CNT_W-1:0]   entry_count;
        t_status            status;
    } t_outcome;

    // Shadow copy of the resident list, head at index 0.
    logic [PID_W-1:0]   res_pid   [MAX_FRAMES];
    logic [PAGE_W-1:0]  res_page  [MAX_FRAMES];
    logic [FRAME_W-1:0] res_frame [MAX_FRAMES];
    int                 resident = 0;
    logic [CFG_W-1:0]   frame_count = 7'd64;
    t_outcome           outcome_q [$];
    int                 mismatches = 0;

    function automatic void drop_entry(int pos);
        for (int i = pos; i + 1 < resident; i++) begin
            res_pid[i]   = res_pid[i+1];
            res_page[i]  = res_page[i+1];
            res_frame[i] = res_frame[i+1];
        end
        if (resident > 0) begin
            resident--;
        end
    endfunction

    function automatic void append_entry(logic [PID_W-1:0] pid, logic [PAGE_W-1:0] page,
                                         logic [FRAME_W-1:0] frame);
        if (resident < MAX_FRAMES) begin
            res_pid[resident]   = pid;
            res_page[resident]  = page;
            res_frame[resident] = frame;
            resident++;
        end
    endfunction

    function automatic t_outcome step_order_list(t_req req, logic [PID_W-1:0] pid,
                                                 logic [PAGE_W-1:0] page,
                                                 logic [FRAME_W-1:0] frame);
        t_outcome           r;
        int                 cap;
        int                 pos;
        logic [PID_W-1:0]   hit_pid;
        logic [PAGE_W-1:0]  hit_page;
        logic [FRAME_W-1:0] hit_frame;
        r = '0;
        r.status = ST_OK;
        cap = int'(frame_count);
        if (cap < 1) begin
            cap = 1;
        end
        if (cap > MAX_FRAMES) begin
            cap = MAX_FRAMES;
        end
        pos = -1;
        case (req)
            REQ_LOAD: begin
                if (resident >= cap) begin
                    r.status = ST_LOAD_FULL;
                end else begin
                    append_entry(pid, page, frame);
                end
            end
            REQ_REPLACE: begin
                if (resident == 0) begin
                    r.status = ST_REPL_EMPTY;
                end else begin
                    r.victim_frame = res_frame[0];
                    r.victim_pid   = res_pid[0];
                    r.victim_page  = res_page[0];
                    drop_entry(0);
                    append_entry(pid, page, r.victim_frame);
                end
            end
            REQ_TOUCH: begin
                // Only the match nearest the head moves to the tail.
                for (int i = 0; i < resident; i++) begin
                    if (pos < 0 && res_pid[i] == pid && res_page[i] == page) begin
                        pos = i;
                    end
                end
                if (pos >= 0) begin
                    r.found   = 1'b1;
                    hit_pid   = res_pid[pos];
                    hit_page  = res_page[pos];
                    hit_frame = res_frame[pos];
                    drop_entry(pos);
                    append_entry(hit_pid, hit_page, hit_frame);
                end
            end
            default: begin
                for (int i = 0; i < resident; i++) begin
                    if (pos < 0 && res_frame[i] == frame) begin
                        pos = i;
                    end
                end
                if (pos >= 0) begin
                    r.found = 1'b1;
                    drop_entry(pos);
                end
            end
        endcase
        r.list_full   = (resident >= cap);
        r.entry_count = CNT_W'(resident);
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    task automatic check_outcome(t_outcome want);
        if (o_victim_frame !== want.victim_frame)
            report_mismatch($sformatf("victim_frame got %0d want %0d",
                                      o_victim_frame, want.victim_frame));
        if (o_victim_pid !== want.victim_pid)
            report_mismatch($sformatf("victim_pid got %0h want %0h",
                                      o_victim_pid, want.victim_pid));
        if (o_victim_page !== want.victim_page)
            report_mismatch($sformatf("victim_page got %0h want %0h",
                                      o_victim_page, want.victim_page));
        if (o_found !== want.found)
            report_mismatch($sformatf("found got %0b want %0b", o_found, want.found));
        if (o_list_full !== want.list_full)
            report_mismatch($sformatf("list_full got %0b want %0b",
                                      o_list_full, want.list_full));
        if (o_entry_count !== want.entry_count)
            report_mismatch($sformatf("entry_count got %0d want %0d",
                                      o_entry_count, want.entry_count));
        if (o_status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", o_status, want.status));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            resident    = 0;
            frame_count = 7'd64;
            outcome_q.delete();
        end else begin
            // A result can never belong to a request taken at the same edge,
            // so results are matched before the new request is predicted.
            if (o_result_valid === 1'b1) begin
                if (outcome_q.size() == 0) begin
                    report_mismatch("result strobe with no request outstanding");
                end else begin
                    check_outcome(outcome_q.pop_front());
                end
            end
            if (start === 1'b1 && busy === 1'b0) begin
                outcome_q.push_back(step_order_list(t_req'(i_req_type), i_proc_id,
                                                    i_page_num, i_frame_num));
            end
            if (i_cfg_valid === 1'b1 && o_cfg_ready === 1'b1) begin
                frame_count = i_cfg_data;
            end
        end
        o_pending    <= outcome_q.size();
        o_fail_count <= mismatches;
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import frl_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASE_COUNT = 8;
    localparam int PHASE_ITEMS = 125;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         i_req_type = REQ_LOAD;
    logic [PID_W-1:0]   i_proc_id = '0;
    logic [PAGE_W-1:0]  i_page_num = '0;
    logic [FRAME_W-1:0] i_frame_num = '0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [CFG_W-1:0]   i_cfg_data = '0;
    logic               o_result_valid;
    logic [FRAME_W-1:0] o_victim_frame;
    logic [PID_W-1:0]   o_victim_pid;
    logic [PAGE_W-1:0]  o_victim_page;
    logic               o_found;
    logic               o_list_full;
    logic [CNT_W-1:0]   o_entry_count;
    logic [1:0]         o_status;
    int                 fail_count;
    int                 pending;
    int                 cycle_count = 0;

    // Sender pacing: start_held tracks whether start was left high after the
    // last transfer, gap_next is the idle time drawn for the next request.
    bit                 start_held = 1'b0;
    int                 gap_next = 0;
    bit                 no_gaps = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    frame_replacement_order_list dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_proc_id      (i_proc_id),
        .i_page_num     (i_page_num),
        .i_frame_num    (i_frame_num),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_victim_frame (o_victim_frame),
        .o_victim_pid   (o_victim_pid),
        .o_victim_page  (o_victim_page),
        .o_found        (o_found),
        .o_list_full    (o_list_full),
        .o_entry_count  (o_entry_count),
        .o_status       (o_status)
    );

    frl_order_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_proc_id      (i_proc_id),
        .i_page_num     (i_page_num),
        .i_frame_num    (i_frame_num),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_victim_frame (o_victim_frame),
        .o_victim_pid   (o_victim_pid),
        .o_victim_page  (o_victim_page),
        .o_found        (o_found),
        .o_list_full    (o_list_full),
        .o_entry_count  (o_entry_count),
        .o_status       (o_status),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Small pools make touches and removes hit resident entries often.
    function automatic logic [PID_W-1:0] pick_pid();
        logic [PID_W-1:0] pool [4];
        pool = '{16'h0000, 16'h0001, 16'hFFFF, 16'h8000};
        if ($urandom_range(0, 9) < 7) begin
            return pool[$urandom_range(0, 3)];
        end
        return PID_W'($urandom_range(0, 65535));
    endfunction

    function automatic logic [PAGE_W-1:0] pick_page();
        logic [PAGE_W-1:0] pool [4];
        pool = '{10'h000, 10'h001, 10'h3FF, 10'h200};
        if ($urandom_range(0, 9) < 7) begin
            return pool[$urandom_range(0, 3)];
        end
        return PAGE_W'($urandom_range(0, 1023));
    endfunction

    function automatic logic [FRAME_W-1:0] pick_frame();
        if ($urandom_range(0, 1) == 0) begin
            return FRAME_W'($urandom_range(0, 7));
        end
        return FRAME_W'($urandom_range(0, 63));
    endfunction

    task automatic issue_request(t_req req, logic [PID_W-1:0] pid, logic [PAGE_W-1:0] page,
                                 logic [FRAME_W-1:0] frame);
        if (!start_held) begin
            repeat (gap_next) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_req_type  <= req;
        i_proc_id   <= pid;
        i_page_num  <= page;
        i_frame_num <= frame;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        // Transfer done at this edge; decide whether the next request follows at once.
        if ($urandom_range(0, 29) == 0) begin
            no_gaps = !no_gaps;
        end
        gap_next = no_gaps ? 0 : $urandom_range(0, 6);
        if (gap_next != 0) begin
            start <= 1'b0;
            start_held = 1'b0;
        end else begin
            start_held = 1'b1;
        end
    endtask

    task automatic wait_list_idle();
        if (start_held) begin
            start <= 1'b0;
            start_held = 1'b0;
        end
        @(posedge i_clk);
        while (pending != 0 || busy) @(posedge i_clk);
    endtask

    task automatic write_frame_count(logic [CFG_W-1:0] value);
        wait_list_idle();
        repeat ($urandom_range(0, 6)) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [CFG_W-1:0] phase_fc [PHASE_COUNT];
        int               phase_load [PHASE_COUNT];
        int               r;
        int               rest;
        t_req             kind;

        phase_fc   = '{7'd8, 7'd64, 7'd1, 7'd0, 7'd127, 7'd2, 7'd100, 7'd12};
        phase_load = '{40, 70, 30, 35, 40, 35, 35, 40};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty list: replace, touch and remove all find nothing.
        issue_request(REQ_REPLACE, 16'h1111, 10'h111, 6'd0);
        issue_request(REQ_TOUCH, 16'h0000, 10'h000, 6'd0);
        issue_request(REQ_REMOVE, 16'h0000, 10'h000, 6'd0);
        // Field extremes, a duplicated pid/page key and a duplicated frame.
        issue_request(REQ_LOAD, 16'hFFFF, 10'h3FF, 6'd63);
        issue_request(REQ_LOAD, 16'h0000, 10'h000, 6'd0);
        issue_request(REQ_LOAD, 16'hFFFF, 10'h3FF, 6'd5);
        issue_request(REQ_LOAD, 16'h1234, 10'h155, 6'd0);
        issue_request(REQ_TOUCH, 16'hFFFF, 10'h3FF, 6'd0);
        issue_request(REQ_TOUCH, 16'h0007, 10'h007, 6'd0);
        issue_request(REQ_REMOVE, 16'h0000, 10'h000, 6'd0);
        issue_request(REQ_REMOVE, 16'h0000, 10'h000, 6'd40);
        issue_request(REQ_REPLACE, 16'h5555, 10'h2AA, 6'd21);
        issue_request(REQ_LOAD, 16'hAAAA, 10'h2AA, 6'd42);
        // Capacity dropped below the current count.
        write_frame_count(7'd1);
        issue_request(REQ_LOAD, 16'h0F0F, 10'h0F0, 6'd9);
        issue_request(REQ_REPLACE, 16'h00FF, 10'h30F, 6'd0);
        issue_request(REQ_TOUCH, 16'h00FF, 10'h30F, 6'd0);
        // Zero acts as a capacity of one.
        write_frame_count(7'd0);
        issue_request(REQ_LOAD, 16'h0001, 10'h001, 6'd1);
        issue_request(REQ_REMOVE, 16'h0000, 10'h000, 6'd63);
        // Values above the list size act as the full size.
        write_frame_count(7'd127);
        issue_request(REQ_LOAD, 16'hFFFF, 10'h3FF, 6'd63);
        issue_request(REQ_REPLACE, 16'h0000, 10'h000, 6'd0);

        for (int p = 0; p < PHASE_COUNT; p++) begin
            if (p == PHASE_COUNT - 1) begin
                write_frame_count(CFG_W'($urandom_range(3, 20)));
            end else begin
                write_frame_count(phase_fc[p]);
            end
            rest = (100 - phase_load[p]) / 3;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Once, in the middle of phase 4, wait until no request is pending or in flight.
                if (p == 4 && n == PHASE_ITEMS / 2) begin
                    wait_list_idle();
                end
                r = $urandom_range(0, 99);
                if (r < phase_load[p]) begin
                    kind = REQ_LOAD;
                end else if (r < phase_load[p] + rest) begin
                    kind = REQ_REPLACE;
                end else if (r < phase_load[p] + 2 * rest) begin
                    kind = REQ_TOUCH;
                end else begin
                    kind = REQ_REMOVE;
                end
                issue_request(kind, pick_pid(), pick_page(), pick_frame());
            end
        end

        wait_list_idle();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
